>>> rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold once the delay dly has passed after the antecedent.
`define ASSERT_DELAYED(lbl, ck, rn, ante, dly, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> ##dly (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/core/fatan_pkg.sv
// Types and constants shared by the arctangent pipeline.
`default_nettype none

package fatan_pkg;

	localparam int IN_W       = 16;
	localparam int ANG_W      = 16;
	localparam int MAG_W      = 16;
	localparam int PROD_W     = 2 * MAG_W;
	localparam int NUM_W      = PROD_W + 3;
	localparam int DEN_W      = PROD_W + 4;
	localparam int RND_SHIFT  = 13;
	localparam int QUO_W      = 13;
	localparam int REM_W      = DEN_W + QUO_W;
	localparam int DIV_STAGES = QUO_W;
	localparam int FRONT_STAGES = 4;
	localparam int LATENCY    = FRONT_STAGES + DIV_STAGES + 1;

	localparam logic [DEN_W-1:0] BIG_COEF   = DEN_W'(25);
	localparam logic [DEN_W-1:0] SMALL_COEF = DEN_W'(7);
	localparam logic [NUM_W-1:0] NUM_COEF   = NUM_W'(25);

	localparam logic signed [ANG_W-1:0] ANG_PI      = 16'sd25736;
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 16'sd12868;

	typedef struct packed {
		logic x_zero;
		logic y_pos;
		logic y_neg;
		logic x_neg;
		logic swap;
	} fatan_ctl_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [DEN_W-1:0] dsr;
		logic [QUO_W-1:0] quo;
		fatan_ctl_t       ctl;
	} fatan_div_t;

endpackage

`default_nettype wire

>>> rtl/core/fatan_front.sv
// Front end: magnitudes, ordering, products, the denominator and the rounded dividend.
`default_nettype none

module fatan_front import fatan_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [IN_W-1:0]   vec_y,
	input  wire logic [IN_W-1:0]   vec_x,
	output logic                   out_valid,
	output fatan_div_t             out_data
);

	logic [MAG_W-1:0] ay, ax;
	fatan_ctl_t       ctl_in;

	logic             valid_s1, valid_s2, valid_s3, valid_s4;
	fatan_ctl_t       ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [MAG_W-1:0] big_s1, small_s1;
	logic [PROD_W-1:0] p_s2, bb_s2, ss_s2;
	logic [NUM_W-1:0] num_s3;
	logic [DEN_W-1:0] den_s3, den_s4;
	logic [REM_W-1:0] rem_s4;

	always_comb begin
		ay = vec_y[IN_W-1] ? (~vec_y + MAG_W'(1)) : vec_y;
		ax = vec_x[IN_W-1] ? (~vec_x + MAG_W'(1)) : vec_x;
		ctl_in.x_zero = (vec_x == '0);
		ctl_in.y_neg  = vec_y[IN_W-1];
		ctl_in.y_pos  = !vec_y[IN_W-1] && (vec_y != '0);
		ctl_in.x_neg  = vec_x[IN_W-1];
		ctl_in.swap   = (ay >= ax);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1   <= ctl_in;
		big_s1   <= ctl_in.swap ? ay : ax;
		small_s1 <= ctl_in.swap ? ax : ay;

		ctl_s2 <= ctl_s1;
		p_s2   <= PROD_W'(big_s1) * PROD_W'(small_s1);
		bb_s2  <= PROD_W'(big_s1) * PROD_W'(big_s1);
		ss_s2  <= PROD_W'(small_s1) * PROD_W'(small_s1);

		ctl_s3 <= ctl_s2;
		num_s3 <= NUM_W'(p_s2) * NUM_COEF;
		den_s3 <= DEN_W'(bb_s2) * BIG_COEF + DEN_W'(ss_s2) * SMALL_COEF;

		ctl_s4 <= ctl_s3;
		den_s4 <= den_s3;
		rem_s4 <= REM_W'({num_s3, RND_SHIFT'(0)}) + REM_W'(den_s3 >> 1);
	end

	assign out_valid     = valid_s4;
	assign out_data.rem  = rem_s4;
	assign out_data.dsr  = den_s4;
	assign out_data.quo  = '0;
	assign out_data.ctl  = ctl_s4;

endmodule

`default_nettype wire

>>> rtl/core/fatan_div_stage.sv
// One restoring division step that produces one quotient bit.
`default_nettype none

module fatan_div_stage import fatan_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  fatan_div_t in_data,
	output logic       out_valid,
	output fatan_div_t out_data
);

	logic [REM_W-1:0] dsh;
	logic [REM_W-1:0] diff;
	logic [REM_W-1:0] sel;
	logic             ge;
	logic             valid_q;
	fatan_div_t       data_q;

	always_comb begin
		dsh  = REM_W'({in_data.dsr, (QUO_W-1)'(0)});
		ge   = (in_data.rem >= dsh);
		diff = in_data.rem - dsh;
		sel  = ge ? diff : in_data.rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q.rem <= {sel[REM_W-2:0], 1'b0};
		data_q.dsr <= in_data.dsr;
		data_q.quo <= {in_data.quo[QUO_W-2:0], ge};
		data_q.ctl <= in_data.ctl;
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

`default_nettype wire

>>> rtl/core/fatan_back.sv
// Back end: signs the quotient and adds the quadrant offsets.
`default_nettype none

module fatan_back import fatan_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  fatan_div_t             in_data,
	output logic                   done,
	output logic signed [ANG_W-1:0] angle
);

	logic signed [ANG_W-1:0] term;
	logic signed [ANG_W-1:0] res;
	logic                    neg;
	logic                    done_q;
	logic signed [ANG_W-1:0] angle_q;

	always_comb begin
		neg  = in_data.ctl.y_neg ^ in_data.ctl.x_neg;
		term = neg ? -$signed(ANG_W'(in_data.quo)) : $signed(ANG_W'(in_data.quo));
		priority if (in_data.ctl.x_zero) begin
			if (in_data.ctl.y_pos) begin
				res = ANG_HALF_PI;
			end else if (in_data.ctl.y_neg) begin
				res = -ANG_HALF_PI;
			end else begin
				res = '0;
			end
		end else if (!in_data.ctl.swap) begin
			if (!in_data.ctl.x_neg) begin
				res = term;
			end else if (in_data.ctl.y_neg) begin
				res = term - ANG_PI;
			end else begin
				res = term + ANG_PI;
			end
		end else begin
			res = in_data.ctl.y_neg ? (ANG_HALF_PI - term - ANG_PI) : (ANG_HALF_PI - term);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		angle_q <= res;
	end

	assign done  = done_q;
	assign angle = angle_q;

endmodule

`default_nettype wire

>>> rtl/core/fast_atan2_approx_top.sv
// Top level of the pipelined four-quadrant arctangent approximation.
//
//   channel   handshake         fields
//   input     start / busy      vec_y, vec_x
//   result    done (strobe)     angle
//
// One beat enters per cycle; busy is never asserted.
// The angle passes through the register stages in order: four front stages
// (ordering, products, denominator, dividend), thirteen restoring division
// stages that each resolve one quotient bit, and one output stage.
// Reset clears the valid bits of every stage; beats in flight are dropped.
// The result strobe cannot be held off, so the pipeline never stalls.
`default_nettype none

module fast_atan2_approx_top import fatan_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic signed [IN_W-1:0] vec_y,
	input  wire logic signed [IN_W-1:0] vec_x,
	output logic                        done,
	output logic signed [ANG_W-1:0]     angle
);

	logic       stg_valid [DIV_STAGES+1];
	fatan_div_t stg_data  [DIV_STAGES+1];

	assign busy = 1'b0;

	fatan_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.vec_y     (vec_y),
		.vec_x     (vec_x),
		.out_valid (stg_valid[0]),
		.out_data  (stg_data[0])
	);

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		fatan_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (stg_valid[i]),
			.in_data   (stg_data[i]),
			.out_valid (stg_valid[i+1]),
			.out_data  (stg_data[i+1])
		);
	end

	fatan_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stg_valid[DIV_STAGES]),
		.in_data  (stg_data[DIV_STAGES]),
		.done     (done),
		.angle    (angle)
	);

endmodule

`default_nettype wire

>>> rtl/core/fatan_checker.sv
// Port-level checks for the arctangent pipeline and their binding.
`default_nettype none
`include "assert_macros.svh"

module fatan_checker import fatan_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   start,
	input wire logic                   busy,
	input wire logic signed [IN_W-1:0] vec_y,
	input wire logic signed [IN_W-1:0] vec_x,
	input wire logic                   done,
	input wire logic signed [ANG_W-1:0] angle
);

	`ASSERT_IMPLIES(a_range, clk, arst_n, done, (angle <= ANG_PI) && (angle >= -ANG_PI))
	`ASSERT_DELAYED(a_latency, clk, arst_n, start && !busy, LATENCY, done)
	`ASSERT_IMPLIES(a_no_spurious, clk, arst_n, done, $past(start && !busy, LATENCY))
	`ASSERT_DELAYED(a_up, clk, arst_n, start && !busy && (vec_x == 0) && (vec_y > 0), LATENCY, angle == ANG_HALF_PI)

endmodule

bind fast_atan2_approx_top fatan_checker u_fatan_checker (.*);

`default_nettype wire

>>> verif/fatan_angle_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the angle of every accepted vector and compares it with the result port.
module fatan_angle_checker import fatan_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic                    busy,
	input  wire logic signed [IN_W-1:0]  vec_y,
	input  wire logic signed [IN_W-1:0]  vec_x,
	input  wire logic                    done,
	input  wire logic signed [ANG_W-1:0] angle,
	output int                           errors,
	output int                           pending
);

	localparam longint unsigned TERM_SCALE = 204800;

	logic signed [ANG_W-1:0] expected_angles [$];
	int err_count  = 0;
	int pend_count = 0;

	assign errors  = err_count;
	assign pending = pend_count;

	function automatic int rounded_term(longint unsigned big, longint unsigned lesser, bit neg);
		longint unsigned num;
		longint unsigned den;
		longint unsigned m;
		num = TERM_SCALE * big * lesser;
		den = 25 * big * big + 7 * lesser * lesser;
		if (den == 0) begin
			return 0;
		end
		m = (num + den / 2) / den;
		return neg ? -int'(m) : int'(m);
	endfunction

	function automatic logic signed [ANG_W-1:0] predict_angle(int y, int x);
		int ay;
		int ax;
		int r;
		bit neg;
		ay  = (y < 0) ? -y : y;
		ax  = (x < 0) ? -x : x;
		neg = (y < 0) != (x < 0);
		if (x == 0) begin
			r = (y > 0) ? int'(ANG_HALF_PI) : (y == 0) ? 0 : -int'(ANG_HALF_PI);
		end else if (ay < ax) begin
			r = rounded_term(ax, ay, neg);
			if (x < 0) begin
				r = (y < 0) ? r - int'(ANG_PI) : r + int'(ANG_PI);
			end
		end else begin
			r = int'(ANG_HALF_PI) - rounded_term(ay, ax, neg);
			if (y < 0) begin
				r = r - int'(ANG_PI);
			end
		end
		return ANG_W'(r);
	endfunction

	always @(posedge clk) begin
		logic signed [ANG_W-1:0] want;
		if (arst_n) begin
			if (done) begin
				if (expected_angles.size() == 0) begin
					if (err_count < 10) begin
						$display("result beat with nothing expected: angle %0d", angle);
					end
					err_count = err_count + 1;
				end else begin
					want = expected_angles.pop_front();
					if (angle !== want) begin
						if (err_count < 10) begin
							$display("angle mismatch: expected %0d, got %0d", want, angle);
						end
						err_count = err_count + 1;
					end
				end
			end
			if (start && !busy) begin
				expected_angles.push_back(predict_angle(vec_y, vec_x));
			end
			pend_count = expected_angles.size();
		end
	end

endmodule

>>> verif/tb_fast_atan2_approx_top.sv
`timescale 1ns / 1ps
// Testbench top that drives vectors into the arctangent pipeline and reports the verdict.
module tb_fast_atan2_approx_top;
	import fatan_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_BEATS = 480;
	localparam int DIRECTED_BEATS = 24;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic signed [IN_W-1:0]  vec_y;
	logic signed [IN_W-1:0]  vec_x;
	logic                    done;
	logic signed [ANG_W-1:0] angle;
	int                      errors;
	int                      pending;
	int                      cycles = 0;

	logic signed [IN_W-1:0] dir_y [DIRECTED_BEATS] = '{
		16'sd0, 16'sd5, -16'sd5, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768, -16'sd32768,
		16'sd32767, 16'sd0, -16'sd32768, 16'sd100, -16'sd100, 16'sd100, -16'sd100, 16'sd1,
		-16'sd1, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1, 16'sd0, 16'sd12345, -16'sd21846
	};
	logic signed [IN_W-1:0] dir_x [DIRECTED_BEATS] = '{
		16'sd0, 16'sd0, 16'sd0, 16'sd5, -16'sd5, 16'sd32767, -16'sd32768, 16'sd32767,
		-16'sd32768, -16'sd32768, 16'sd0, -16'sd100, -16'sd100, 16'sd100, 16'sd100, 16'sd32767,
		-16'sd32768, 16'sd1, -16'sd1, -16'sd1, 16'sd1, 16'sd1, -16'sd6789, 16'sd21845
	};
	logic signed [IN_W-1:0] edge_vals [8] = '{
		-16'sd32768, -16'sd32767, -16'sd2, -16'sd1, 16'sd0, 16'sd1, 16'sd32766, 16'sd32767
	};

	fast_atan2_approx_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.vec_y  (vec_y),
		.vec_x  (vec_x),
		.done   (done),
		.angle  (angle)
	);

	fatan_angle_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.vec_y   (vec_y),
		.vec_x   (vec_x),
		.done    (done),
		.angle   (angle),
		.errors  (errors),
		.pending (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_vector(logic signed [IN_W-1:0] y, logic signed [IN_W-1:0] x);
		start <= 1'b1;
		vec_y <= y;
		vec_x <= x;
		do @(negedge clk); while (busy);
		@(posedge clk);
	endtask

	task automatic hold_off(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain_pipeline();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	function automatic int random_gap();
		int g;
		g = $urandom_range(0, 99);
		if (g < 60) begin
			return 0;
		end else if (g < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	initial begin
		logic signed [IN_W-1:0] y;
		logic signed [IN_W-1:0] x;
		int kind;
		arst_n <= 1'b0;
		start  <= 1'b0;
		vec_y  <= '0;
		vec_x  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_BEATS; i++) begin
			send_vector(dir_y[i], dir_x[i]);
			hold_off(i % 3);
		end
		drain_pipeline();

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			kind = $urandom_range(0, 9);
			case (kind)
				5: begin
					y = IN_W'($urandom_range(0, 64)) - 16'sd32;
					x = IN_W'($urandom_range(0, 64)) - 16'sd32;
				end
				6: begin
					y = IN_W'($urandom);
					x = IN_W'($urandom);
					if ($urandom_range(0, 1)) y = '0; else x = '0;
				end
				7: begin
					y = IN_W'($urandom);
					x = $urandom_range(0, 1) ? y : -y;
				end
				8: begin
					y = edge_vals[$urandom_range(0, 7)];
					x = edge_vals[$urandom_range(0, 7)];
				end
				9: begin
					y = IN_W'($urandom);
					x = y + IN_W'($urandom_range(0, 6)) - 16'sd3;
					if ($urandom_range(0, 1)) x = -x;
				end
				default: begin
					y = IN_W'($urandom);
					x = IN_W'($urandom);
				end
			endcase
			send_vector(y, x);
			if (i == RANDOM_BEATS / 2) begin
				drain_pipeline();
			end else if (i % 60 < 45) begin
				hold_off(random_gap());
			end
		end

		drain_pipeline();
		repeat (LATENCY + 10) @(posedge clk);
		@(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/fatan_pkg.sv
rtl/core/fatan_front.sv
rtl/core/fatan_div_stage.sv
rtl/core/fatan_back.sv
rtl/core/fast_atan2_approx_top.sv
rtl/core/fatan_checker.sv
verif/fatan_angle_checker.sv
verif/tb_fast_atan2_approx_top.sv
